// ----- src/trs_pkg.sv -----
`default_nettype none

package trs_pkg;

    localparam int QUAT_W  = 16;
    localparam int SCL_W   = 24;
    localparam int TRN_W   = 32;
    localparam int QPR_W   = 2 * QUAT_W;
    localparam int ROT_W   = QPR_W + 2;
    localparam int WPR_W   = ROT_W + SCL_W;
    localparam int RSUM_W  = WPR_W + 1;
    localparam int FRAC_DROP = 30;
    localparam int N_ENT   = 9;

    typedef logic signed [QUAT_W-1:0] t_quat;
    typedef logic signed [SCL_W-1:0]  t_scale;
    typedef logic signed [TRN_W-1:0]  t_trans;
    typedef logic signed [QPR_W-1:0]  t_qprod;
    typedef logic signed [ROT_W-1:0]  t_rot;
    typedef logic signed [WPR_W-1:0]  t_wprod;
    typedef logic signed [RSUM_W-1:0] t_rsum;
    typedef logic signed [SCL_W-1:0]  t_ent;

    localparam t_rot  ONE_Q30  = t_rot'(64'sd1 <<< FRAC_DROP);
    localparam t_rsum HALF_Q30 = t_rsum'(64'sd1 <<< (FRAC_DROP - 1));
    localparam t_rsum ENT_MAX  = t_rsum'((64'sd1 <<< (SCL_W - 1)) - 64'sd1);
    localparam t_rsum ENT_MIN  = t_rsum'(-(64'sd1 <<< (SCL_W - 1)));

    // Input item, last field (qx) in the lowest bits.
    typedef struct packed {
        t_trans tz;
        t_trans ty;
        t_trans tx;
        t_scale sz;
        t_scale sy;
        t_scale sx;
        t_quat  qw;
        t_quat  qz;
        t_quat  qy;
        t_quat  qx;
    } t_in;

    typedef struct packed {
        t_trans tz;
        t_trans ty;
        t_trans tx;
    } t_tvec;

    typedef struct packed {
        t_scale sz;
        t_scale sy;
        t_scale sx;
    } t_svec;

    typedef struct packed {
        t_tvec  trn;
        t_svec  scl;
        t_qprod xx;
        t_qprod yy;
        t_qprod zz;
        t_qprod xy;
        t_qprod xz;
        t_qprod yz;
        t_qprod wx;
        t_qprod wy;
        t_qprod wz;
    } t_s1;

    // Rotation entries in column-major order, Q.30.
    typedef struct packed {
        t_tvec              trn;
        t_svec              scl;
        t_rot [N_ENT-1:0]   rot;
    } t_s2;

    typedef struct packed {
        t_tvec              trn;
        t_wprod [N_ENT-1:0] prd;
    } t_s3;

    // Result item, col0_x in the lowest bits.
    typedef struct packed {
        t_tvec            trn;
        t_ent [N_ENT-1:0] ent;
    } t_out;

endpackage

`default_nettype wire

// ----- src/trs_quat_prod.sv -----
`default_nettype none

module trs_quat_prod (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_valid,
    output logic           o_ready,
    input  trs_pkg::t_in   i_data,
    output logic           o_valid,
    input  wire            i_ready,
    output trs_pkg::t_s1   o_data
);
    import trs_pkg::*;

    logic r_valid;
    t_s1  r_data;
    t_s1  n_data;

    // Nine exact Q2.30 products of the quaternion components.
    always_comb begin
        n_data.trn = '{tz: i_data.tz, ty: i_data.ty, tx: i_data.tx};
        n_data.scl = '{sz: i_data.sz, sy: i_data.sy, sx: i_data.sx};
        n_data.xx  = i_data.qx * i_data.qx;
        n_data.yy  = i_data.qy * i_data.qy;
        n_data.zz  = i_data.qz * i_data.qz;
        n_data.xy  = i_data.qx * i_data.qy;
        n_data.xz  = i_data.qx * i_data.qz;
        n_data.yz  = i_data.qy * i_data.qz;
        n_data.wx  = i_data.qw * i_data.qx;
        n_data.wy  = i_data.qw * i_data.qy;
        n_data.wz  = i_data.qw * i_data.qz;
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

// ----- src/trs_rot_build.sv -----
`default_nettype none

module trs_rot_build (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_valid,
    output logic           o_ready,
    input  trs_pkg::t_s1   i_data,
    output logic           o_valid,
    input  wire            i_ready,
    output trs_pkg::t_s2   o_data
);
    import trs_pkg::*;

    logic r_valid;
    t_s2  r_data;
    t_s2  n_data;

    // Rotation matrix in Q.30; sums are widened before the doubling.
    always_comb begin
        n_data.trn    = i_data.trn;
        n_data.scl    = i_data.scl;
        n_data.rot[0] = ONE_Q30 - ((t_rot'(i_data.yy) + t_rot'(i_data.zz)) <<< 1);
        n_data.rot[1] = (t_rot'(i_data.xy) + t_rot'(i_data.wz)) <<< 1;
        n_data.rot[2] = (t_rot'(i_data.xz) - t_rot'(i_data.wy)) <<< 1;
        n_data.rot[3] = (t_rot'(i_data.xy) - t_rot'(i_data.wz)) <<< 1;
        n_data.rot[4] = ONE_Q30 - ((t_rot'(i_data.xx) + t_rot'(i_data.zz)) <<< 1);
        n_data.rot[5] = (t_rot'(i_data.yz) + t_rot'(i_data.wx)) <<< 1;
        n_data.rot[6] = (t_rot'(i_data.xz) + t_rot'(i_data.wy)) <<< 1;
        n_data.rot[7] = (t_rot'(i_data.yz) - t_rot'(i_data.wx)) <<< 1;
        n_data.rot[8] = ONE_Q30 - ((t_rot'(i_data.xx) + t_rot'(i_data.yy)) <<< 1);
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

// ----- src/trs_scale_mul.sv -----
`default_nettype none

module trs_scale_mul (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_valid,
    output logic           o_ready,
    input  trs_pkg::t_s2   i_data,
    output logic           o_valid,
    input  wire            i_ready,
    output trs_pkg::t_s3   o_data
);
    import trs_pkg::*;

    logic r_valid;
    t_s3  r_data;
    t_s3  n_data;

    // Column j takes scale j; products are exact in Q.46.
    always_comb begin
        n_data.trn = i_data.trn;
        for (int i = 0; i < N_ENT; i++) begin
            unique case (i / 3)
                0:       n_data.prd[i] = i_data.rot[i] * i_data.scl.sx;
                1:       n_data.prd[i] = i_data.rot[i] * i_data.scl.sy;
                default: n_data.prd[i] = i_data.rot[i] * i_data.scl.sz;
            endcase
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

// ----- src/trs_round_sat.sv -----
`default_nettype none

module trs_round_sat (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_valid,
    output logic           o_ready,
    input  trs_pkg::t_s3   i_data,
    output logic           o_valid,
    input  wire            i_ready,
    output trs_pkg::t_out  o_data
);
    import trs_pkg::*;

    logic  r_valid;
    t_out  r_data;
    t_out  n_data;
    t_rsum rnd [N_ENT];

    // Round half up to Q8.16, then clamp to the 24-bit range.
    always_comb begin
        n_data.trn = i_data.trn;
        for (int i = 0; i < N_ENT; i++) begin
            rnd[i] = (t_rsum'(i_data.prd[i]) + HALF_Q30) >>> FRAC_DROP;
            if (rnd[i] > ENT_MAX) begin
                n_data.ent[i] = ENT_MAX[SCL_W-1:0];
            end else if (rnd[i] < ENT_MIN) begin
                n_data.ent[i] = ENT_MIN[SCL_W-1:0];
            end else begin
                n_data.ent[i] = rnd[i][SCL_W-1:0];
            end
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

// ----- src/trs_matrix_compose.sv -----
// Channel   | Dir | Bits | Fields, lowest bit first
// ----------+-----+------+------------------------------------------------------------
// s (in)    | in  | 232  | quat_x/y/z/w 16 each, scale_x/y/z 24 each, trans_in_x/y/z 32 each
// m (out)   | out | 312  | col0_x..col2_z 24 each (column-major), out_trans_x/y/z 32 each
//
// One item per cycle sustained while i_m_tready is high. Five register stages: quaternion
// products, rotation build, scale multiply, round/clamp, output register. The widest path
// is the 34 x 24 scale multiply stage.
// Synchronous active-low reset clears every valid bit; data registers hold garbage.
// Each stage advances when empty or when the next one advances. A two-entry output
// register (main plus skid) keeps o_s_tready free of any path from i_m_tready.
`default_nettype none

module trs_matrix_compose (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_s_tvalid,
    output logic         o_s_tready,
    // quat_x, quat_y, quat_z, quat_w, scale_x, scale_y, scale_z,
    // trans_in_x, trans_in_y, trans_in_z
    input  wire  [231:0] i_s_tdata,
    output logic         o_m_tvalid,
    input  wire          i_m_tready,
    // col0_x, col0_y, col0_z, col1_x, col1_y, col1_z, col2_x, col2_y, col2_z,
    // out_trans_x, out_trans_y, out_trans_z
    output logic [311:0] o_m_tdata
);
    import trs_pkg::*;

    // Stage handshakes.
    logic s1_valid, s1_ready;
    logic s2_valid, s2_ready;
    logic s3_valid, s3_ready;
    logic s4_valid, s4_ready;
    t_s1  s1_data;
    t_s2  s2_data;
    t_s3  s3_data;
    t_out s4_data;

    // Output register and its skid slot.
    logic r_out_valid;
    t_out r_out_data;
    logic r_skid_valid;
    t_out r_skid_data;
    logic push;
    logic pop;

    trs_quat_prod u_quat_prod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_data  (t_in'(i_s_tdata)),
        .o_valid (s1_valid),
        .i_ready (s1_ready),
        .o_data  (s1_data)
    );

    trs_rot_build u_rot_build (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s1_valid),
        .o_ready (s1_ready),
        .i_data  (s1_data),
        .o_valid (s2_valid),
        .i_ready (s2_ready),
        .o_data  (s2_data)
    );

    trs_scale_mul u_scale_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s2_valid),
        .o_ready (s2_ready),
        .i_data  (s2_data),
        .o_valid (s3_valid),
        .i_ready (s3_ready),
        .o_data  (s3_data)
    );

    trs_round_sat u_round_sat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s3_valid),
        .o_ready (s3_ready),
        .i_data  (s3_data),
        .o_valid (s4_valid),
        .i_ready (s4_ready),
        .o_data  (s4_data)
    );

    // The skid slot only fills while the output register is stalled, so ready
    // toward the pipeline is simply "skid empty".
    assign s4_ready = !r_skid_valid;
    assign push     = s4_valid && s4_ready;
    assign pop      = r_out_valid && i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || pop) begin
            // Output slot frees up: drain the skid first, else take the new item.
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= push;
            end
        end else if (push) begin
            // Output stalled: park the item.
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || pop) begin
            if (r_skid_valid) begin
                r_out_data <= r_skid_data;
            end else if (push) begin
                r_out_data <= s4_data;
            end
        end else if (push) begin
            r_skid_data <= s4_data;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    // The skid slot never holds an item while the output slot is empty.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid slot full while output register empty");

    // After the last stage hands over an item, the output register holds a valid item next cycle.
    a_push_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |=> r_out_valid)
        else $error("item from round stage lost at output");

    // A stalled first stage keeps its item.
    a_s1_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_valid && !s1_ready) |=> (s1_valid && $stable(s1_data)))
        else $error("first stage dropped or changed a stalled item");

endmodule

`default_nettype wire

// ----- dv/trs_matrix_compose_tb.sv -----
`timescale 1ns / 1ps

module trs_matrix_compose_tb;

    import trs_pkg::*;

    localparam int N_PHASES       = 4;
    localparam int RAND_PER_PHASE = 383;
    localparam int SETTLE_CYCLES  = 16;

    // Percent of cycles the sender idles / the receiver stalls, per phase.
    localparam int GAP_PCT[N_PHASES]   = '{0, 84, 0, 20};
    localparam int STALL_PCT[N_PHASES] = '{0, 0, 84, 20};

    // Quaternion components that land on exact angles or the range ends.
    localparam int QUAT_PICKS[8] = '{0, 16384, -16384, 23170, -23170, 32767, -32768, 1};

    // Holds the matrices still owed by the block, oldest first, and grades results.
    class trs_scoreboard;
        t_out owed[$];
        int   items_in;
        int   results_out;
        int   faults;

        // Q.30 rotation entry times Q8.16 scale, rounded half up to Q8.16, clamped.
        static function t_ent round_clamp(longint rot, longint scl);
            longint p;
            p = rot * scl;
            p = (p + longint'(HALF_Q30)) >>> FRAC_DROP;
            if (p > longint'(ENT_MAX)) p = longint'(ENT_MAX);
            if (p < longint'(ENT_MIN)) p = longint'(ENT_MIN);
            return t_ent'(p);
        endfunction

        static function t_out compose_matrix(t_in it);
            longint x, y, z, w;
            longint xx, yy, zz, xy, xz, yz, wx, wy, wz;
            longint one;
            longint rot[N_ENT];
            longint scl[3];
            t_out   m;
            x = longint'(it.qx);
            y = longint'(it.qy);
            z = longint'(it.qz);
            w = longint'(it.qw);
            scl[0] = longint'(it.sx);
            scl[1] = longint'(it.sy);
            scl[2] = longint'(it.sz);
            one = longint'(ONE_Q30);
            xx = x * x; yy = y * y; zz = z * z;
            xy = x * y; xz = x * z; yz = y * z;
            wx = w * x; wy = w * y; wz = w * z;
            // column-major: entry k belongs to column k/3
            rot[0] = one - 2 * (yy + zz);
            rot[1] = 2 * (xy + wz);
            rot[2] = 2 * (xz - wy);
            rot[3] = 2 * (xy - wz);
            rot[4] = one - 2 * (xx + zz);
            rot[5] = 2 * (yz + wx);
            rot[6] = 2 * (xz + wy);
            rot[7] = 2 * (yz - wx);
            rot[8] = one - 2 * (xx + yy);
            for (int k = 0; k < N_ENT; k++) begin
                m.ent[k] = round_clamp(rot[k], scl[k / 3]);
            end
            m.trn.tx = it.tx;
            m.trn.ty = it.ty;
            m.trn.tz = it.tz;
            return m;
        endfunction

        function void report(string what, logic signed [31:0] want, logic signed [31:0] got);
            faults++;
            if (faults <= 10) begin
                $display("[%0t] result %0d %s: expected %0d (0x%h), got %0d (0x%h)",
                         $realtime, results_out, what, want, want, got, got);
            end
        endfunction

        function void note_input(t_in it);
            items_in++;
            owed.push_back(compose_matrix(it));
        endfunction

        function void check_result(t_out got);
            t_out  want;
            string axes;
            axes = "xyz";
            results_out++;
            if (owed.size() == 0) begin
                report("arrived with no item pending", 0, 0);
                return;
            end
            want = owed.pop_front();
            for (int k = 0; k < N_ENT; k++) begin
                if (got.ent[k] !== want.ent[k]) begin
                    report($sformatf("col%0d_%c", k / 3, axes[k % 3]),
                           32'(want.ent[k]), 32'(got.ent[k]));
                end
            end
            if (got.trn.tx !== want.trn.tx) report("out_trans_x", want.trn.tx, got.trn.tx);
            if (got.trn.ty !== want.trn.ty) report("out_trans_y", want.trn.ty, got.trn.ty);
            if (got.trn.tz !== want.trn.tz) report("out_trans_z", want.trn.tz, got.trn.tz);
        endfunction
    endclass

    logic         i_clk      = 1'b0;
    logic         i_rst_n    = 1'b0;
    logic         i_s_tvalid = 1'b0;
    logic [231:0] i_s_tdata  = '0;
    logic         i_m_tready = 1'b0;
    logic         o_s_tready;
    logic         o_m_tvalid;
    logic [311:0] o_m_tdata;

    trs_scoreboard book = new();
    int            gap_pct   = 0;
    int            stall_pct = 0;
    int            n_directed = 0;

    trs_matrix_compose dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Throttle the result side; stall_pct of zero keeps tready high.
    always @(posedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Sample both handshakes on the edge, before the block's registers move.
    always @(posedge i_clk) begin
        if (i_rst_n && i_s_tvalid && o_s_tready) begin
            book.note_input(t_in'(i_s_tdata));
        end
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            book.check_result(t_out'(o_m_tdata));
        end
    end

    function automatic t_in make_item(int qx, int qy, int qz, int qw,
                                      int sx, int sy, int sz,
                                      logic [31:0] tx, logic [31:0] ty, logic [31:0] tz);
        t_in it;
        it.qx = t_quat'(qx); it.qy = t_quat'(qy); it.qz = t_quat'(qz); it.qw = t_quat'(qw);
        it.sx = t_scale'(sx); it.sy = t_scale'(sy); it.sz = t_scale'(sz);
        it.tx = tx; it.ty = ty; it.tz = tz;
        return it;
    endfunction

    function automatic int pick_quat();
        return QUAT_PICKS[$urandom_range(7)];
    endfunction

    // Mild scale: within +/- 64.0 so most products stay clear of the clamp.
    function automatic int mild_scale();
        return int'($urandom_range(8388607)) - 4194304;
    endfunction

    function automatic t_in random_item();
        t_in    it;
        longint rem;
        int     w;
        it.tx = $urandom;
        it.ty = $urandom;
        it.tz = $urandom;
        case ($urandom_range(3))
            0: begin
                // raw bits everywhere, mostly saturating
                it.qx = t_quat'($urandom); it.qy = t_quat'($urandom);
                it.qz = t_quat'($urandom); it.qw = t_quat'($urandom);
                it.sx = t_scale'($urandom); it.sy = t_scale'($urandom);
                it.sz = t_scale'($urandom);
            end
            1: begin
                // exact-angle components, moderate scale
                it.qx = t_quat'(pick_quat()); it.qy = t_quat'(pick_quat());
                it.qz = t_quat'(pick_quat()); it.qw = t_quat'(pick_quat());
                it.sx = t_scale'(mild_scale()); it.sy = t_scale'(mild_scale());
                it.sz = t_scale'(mild_scale());
            end
            2: begin
                // near-unit quaternion: draw x, y, z, solve w
                it.qx = t_quat'(int'($urandom_range(36000)) - 18000);
                it.qy = t_quat'(int'($urandom_range(36000)) - 18000);
                it.qz = t_quat'(int'($urandom_range(36000)) - 18000);
                rem = (longint'(1) << 30) - longint'(it.qx) * it.qx
                      - longint'(it.qy) * it.qy - longint'(it.qz) * it.qz;
                w = $rtoi($sqrt(real'(rem)));
                if (w > 32767) w = 32767;
                it.qw = $urandom_range(1) ? t_quat'(-w) : t_quat'(w);
                it.sx = t_scale'(mild_scale()); it.sy = t_scale'(mild_scale());
                it.sz = t_scale'(mild_scale());
            end
            default: begin
                it.qx = t_quat'($urandom); it.qy = t_quat'($urandom);
                it.qz = t_quat'($urandom); it.qw = t_quat'($urandom);
                it.sx = t_scale'(mild_scale()); it.sy = t_scale'(mild_scale());
                it.sz = t_scale'(mild_scale());
            end
        endcase
        return it;
    endfunction

    // Offer one item, idling first at the current gap rate; return on acceptance.
    task automatic push_item(input t_in it);
        while ($urandom_range(99) < gap_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= it;
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    // Hold the sender off until every owed matrix has come back.
    task automatic wait_drained();
        do @(posedge i_clk); while (book.owed.size() != 0);
    endtask

    task automatic push_directed(input t_in it);
        n_directed++;
        push_item(it);
    endtask

    task automatic run_directed();
        // zero quaternion and zero scale
        push_directed(make_item(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        // near identity at unit scale
        push_directed(make_item(0, 0, 0, 32767, 65536, 65536, 65536, 32'h0001_0000,
                                32'hFFFF_0000, 32'h7FFF_FFFF));
        // w of exactly -1.0
        push_directed(make_item(0, 0, 0, -32768, 65536, 65536, 65536, 32'h8000_0000,
                                32'hFFFF_FFFF, 32'h0000_0001));
        // half turns about each axis, scale at the ends
        push_directed(make_item(-32768, 0, 0, 0, 8388607, 8388607, 8388607, 0, 0, 0));
        push_directed(make_item(0, -32768, 0, 0, -8388608, -8388608, -8388608, 1, 2, 3));
        push_directed(make_item(0, 0, -32768, 0, 8388607, -8388608, 65536, 5, 6, 7));
        // non-unit quaternions, driven into saturation both ways
        push_directed(make_item(-32768, -32768, -32768, -32768, 8388607, 8388607, 8388607,
                                32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        push_directed(make_item(32767, 32767, 32767, 32767, -8388608, -8388608, -8388608,
                                32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        push_directed(make_item(-32768, -32768, -32768, -32768, -8388608, -8388608, -8388608,
                                32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        push_directed(make_item(32767, -32768, 32767, -32768, 8388607, -8388608, 8388607,
                                32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA));
        // quarter turn about z
        push_directed(make_item(0, 0, 23170, 23170, 65536, 65536, 65536, 0, 0, 0));
        // rounding ties: +half rounds up, -half rounds toward zero
        push_directed(make_item(128, 128, 0, 0, 16384, 16384, 16384, 0, 0, 0));
        push_directed(make_item(128, 128, 0, 0, -16384, -16384, -16384, 0, 0, 0));
        // smallest scales of either sign
        push_directed(make_item(16384, -16384, 16384, 16384, 1, -1, 1, 0, 0, 0));
        push_directed(make_item(1, -1, 1, -1, -1, 1, -1, 32'h0000_FFFF, 32'hFFFF_0000, 0));
        // mixed sign components, largest negative scale on one axis only
        push_directed(make_item(-16384, 16384, -23170, 23170, -8388608, 65536, 8388607,
                                32'h1234_5678, 32'h8765_4321, 32'hDEAD_BEEF));
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int ph = 0; ph < N_PHASES; ph++) begin
            gap_pct   = GAP_PCT[ph];
            stall_pct <= STALL_PCT[ph];
            if (ph == 0) begin
                run_directed();
            end
            repeat (RAND_PER_PHASE) push_item(random_item());
            i_s_tvalid <= 1'b0;
            wait_drained();
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (book.owed.size() != 0) begin
            book.report("matrices never returned", book.owed.size(), 0);
        end

        $display("Sent %0d items (%0d directed) through %0d throttle phases.",
                 book.items_in, n_directed, N_PHASES);
        $display("Checked %0d matrices, %0d faults.", book.results_out, book.faults);
        if (book.faults == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Hard stop well beyond the slowest legal run.
    initial begin
        #5_000_000;
        $display("Timeout: %0d matrices still owed", book.owed.size());
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- files.f -----
src/trs_pkg.sv
src/trs_quat_prod.sv
src/trs_rot_build.sv
src/trs_scale_mul.sv
src/trs_round_sat.sv
src/trs_matrix_compose.sv
dv/trs_matrix_compose_tb.sv
